/* src/dck4_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the dihedral Cayley graph four-clique detector.
// Depends on nothing.
package dck4_pkg;

	localparam int MAX_ELEMS = 64;

	localparam logic [1:0] FUNC_FULL     = 2'd0;
	localparam logic [1:0] FUNC_COMPLETE = 2'd1;
	localparam logic [1:0] FUNC_COMPL    = 2'd2;

	typedef struct packed {
		logic [MAX_ELEMS-1:0] set;
		logic [5:0]           x;
		logic                 three;
		logic                 triv;
	} dck4_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} dck4_state_t;

endpackage

/* src/dck4_front.sv */
`timescale 1ns / 1ps
// Front end: accepts items and classifies them into search jobs for the queue.
// Depends on dck4_pkg.
module dck4_front #(
	parameter int HALF_ORDER = 22
) (
	input  logic              start,
	input  logic [1:0]        func,
	input  logic [43:0]       conn_mask,
	input  logic [5:0]        new_element,
	input  logic              full,
	output logic              push,
	output dck4_pkg::dck4_entry_t entry
);
	import dck4_pkg::*;

	localparam int N  = 2 * HALF_ORDER;
	localparam int MW = (N > 44) ? N : 44;

	logic [MW-1:0] mext;
	logic [N-1:0]  grp;
	logic [N-1:0]  s;

	always_comb begin
		mext = MW'(conn_mask);
		grp  = {{(N-1){1'b1}}, 1'b0};
		s    = mext[N-1:0] & grp;
		push = start && !full;
		entry.x     = new_element;
		entry.three = (func == FUNC_COMPLETE);
		entry.set   = MAX_ELEMS'(s);
		entry.triv  = 1'b1;
		case (func)
			FUNC_FULL: begin
				entry.triv = 1'b0;
			end
			FUNC_COMPLETE: begin
				entry.triv = (7'(new_element) >= 7'(N));
			end
			FUNC_COMPL: begin
				entry.set  = MAX_ELEMS'(grp ^ s);
				entry.triv = 1'b0;
			end
			default: begin
				entry.triv = 1'b1;
			end
		endcase
	end

endmodule

/* src/dck4_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between the front end and the search engine.
// Depends on dck4_pkg.
module dck4_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dck4_pkg::dck4_entry_t wdata,
	output dck4_pkg::dck4_entry_t rdata,
	input  logic                  push,
	input  logic                  pop,
	output logic                  full,
	output logic                  empty
);
	import dck4_pkg::*;

	dck4_entry_t mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

/* src/dck4_back.sv */
`timescale 1ns / 1ps
// Search engine: depth-first walk over set members, one candidate a cycle except in cycles that step back a level.
// Depends on dck4_pkg.
module dck4_back #(
	parameter int HALF_ORDER = 22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dck4_pkg::dck4_entry_t entry,
	input  logic                  empty,
	output logic                  pop,
	output logic                  done,
	output logic                  found
);
	import dck4_pkg::*;

	localparam int N  = 2 * HALF_ORDER;
	localparam int EW = $clog2(N);
	localparam int W  = $clog2(N + 1);
	localparam int KW = $clog2(HALF_ORDER);

	function automatic logic lnk(input logic [N-1:0] s, input logic [EW-1:0] g,
		input logic [EW-1:0] h);
		logic          gs;
		logic          hs;
		logic [KW-1:0] gk;
		logic [KW-1:0] hk;
		logic [KW:0]   dif;
		logic [EW-1:0] p;
		gs = (g >= EW'(HALF_ORDER));
		hs = (h >= EW'(HALF_ORDER));
		gk = gs ? KW'(g - EW'(HALF_ORDER)) : KW'(g);
		hk = hs ? KW'(h - EW'(HALF_ORDER)) : KW'(h);
		dif = gs ? ({1'b0, gk} - {1'b0, hk}) : ({1'b0, hk} - {1'b0, gk});
		if (dif[KW]) begin
			dif = dif + (KW+1)'(HALF_ORDER);
		end
		p = EW'(dif[KW-1:0]);
		if (gs != hs) begin
			p = p + EW'(HALF_ORDER);
		end
		return s[p];
	endfunction

	dck4_state_t   state_q;
	logic [N-1:0]  set_q;
	logic [EW-1:0] x_q;
	logic          three_q;
	logic          triv_q;
	logic [W-1:0]  idx_q [4];
	logic [1:0]    lvl_q;
	logic          done_q;
	logic          found_q;

	logic [W-1:0]  v;
	logic [EW-1:0] ve;
	logic          ok;
	logic [1:0]    last;

	assign pop   = (state_q == ST_IDLE) && !empty;
	assign done  = done_q;
	assign found = found_q;

	always_comb begin
		v    = idx_q[lvl_q];
		ve   = v[EW-1:0];
		last = three_q ? 2'd2 : 2'd3;
		ok   = set_q[ve] && !(three_q && (ve == x_q));
		for (int j = 0; j < 3; j++) begin
			if (2'(j) < lvl_q && !lnk(set_q, idx_q[j][EW-1:0], ve)) begin
				ok = 1'b0;
			end
		end
		if (three_q && !lnk(set_q, ve, x_q)) begin
			ok = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			set_q   <= entry.set[N-1:0];
			x_q     <= EW'(entry.x);
			three_q <= entry.three;
			triv_q  <= entry.triv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= 2'd0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			for (int j = 0; j < 4; j++) begin
				idx_q[j] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q  <= ST_RUN;
						lvl_q    <= 2'd0;
						idx_q[0] <= W'(1);
					end
				end
				ST_RUN: begin
					if (triv_q) begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
						state_q <= ST_IDLE;
					end else if (v >= W'(N)) begin
						if (lvl_q == 2'd0) begin
							done_q  <= 1'b1;
							found_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							lvl_q <= lvl_q - 2'd1;
							idx_q[lvl_q - 2'd1] <= idx_q[lvl_q - 2'd1] + W'(1);
						end
					end else if (ok) begin
						if (lvl_q == last) begin
							done_q  <= 1'b1;
							found_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							lvl_q <= lvl_q + 2'd1;
							idx_q[lvl_q + 2'd1] <= v + W'(1);
						end
					end else begin
						idx_q[lvl_q] <= v + W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_RUN)) else $error("result without search");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held");
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && three_q) |-> lvl_q <= 2'd2) else $error("depth overrun");

endmodule

/* src/dihedral_cayley_k4_detect.sv */
`timescale 1ns / 1ps
// Top level of the dihedral Cayley graph four-clique detector.
// Depends on dck4_pkg, dck4_front, dck4_queue and dck4_back.
//
//  channel  handshake         payload
//  input    start / busy      func, conn_mask, new_element
//  result   done (strobe)     found
//
// An item passes through the queue to the search engine, which takes it when idle and
// then tests one candidate element a cycle in a depth-first walk, apart from cycles
// that step back a level. A trivial item is answered without a search; any other
// search lasts as long as the edges and triangles that it passes through demand.
// Two items may wait in the queue while one is searched; busy is high while it is full.
// Reset clears the queue and the engine; the receiver cannot stall results.
module dihedral_cayley_k4_detect #(
	parameter int HALF_ORDER = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [43:0] conn_mask,
	input  logic [5:0]  new_element,
	output logic        done,
	output logic        found
);
	import dck4_pkg::*;

	dck4_entry_t wentry;
	dck4_entry_t rentry;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	assign busy = q_full;

	dck4_front #(.HALF_ORDER(HALF_ORDER)) u_front (
		.start(start), .func(func), .conn_mask(conn_mask), .new_element(new_element),
		.full(q_full), .push(q_push), .entry(wentry)
	);

	dck4_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wdata(wentry), .rdata(rentry),
		.push(q_push), .pop(q_pop), .full(q_full), .empty(q_empty)
	);

	dck4_back #(.HALF_ORDER(HALF_ORDER)) u_back (
		.clk(clk), .arst_n(arst_n), .entry(rentry), .empty(q_empty),
		.pop(q_pop), .done(done), .found(found)
	);

endmodule
